// ===== hw/rtl/sha256_hash_engine_core_assert.svh =====
// assertion macros used by the hash back end
`ifndef SHA256_HASH_ENGINE_CORE_ASSERT_SVH
`define SHA256_HASH_ENGINE_CORE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define SHE_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
// next-cycle implication
`define SHE_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

// ===== hw/rtl/she_pkg.sv =====
`timescale 1ns / 1ps
package she_pkg;
   localparam int unsigned QueueDepth = 4;

   // one queued request: absorb a byte or finish
   typedef struct packed {
      logic       finish;
      logic [7:0] data_byte;
   } req_item_type;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
      32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
      32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
      32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
      32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
      32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
      32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
      32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
      32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
      32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
      32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;

   function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
      rotr = (v >> n) | (v << (32 - n));
   endfunction
endpackage

// ===== hw/rtl/she_front.sv =====
`timescale 1ns / 1ps
// input queue between the stream port and the hash back end
module she_front import she_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output req_item_type out_item
);
   localparam int unsigned AW = $clog2(QueueDepth);

   req_item_type    mem_ff [QueueDepth];
   logic [AW-1:0]   wr_ff, rd_ff;
   logic [AW:0]     cnt_ff;
   logic            push, pop;

   assign in_ready  = (cnt_ff != (AW+1)'(QueueDepth));
   assign out_valid = (cnt_ff != '0);
   assign out_item  = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   // entry storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_item;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end
endmodule

// ===== hw/rtl/she_back.sv =====
`timescale 1ns / 1ps
`include "sha256_hash_engine_core_assert.svh"
// padding sequencer, compression rounds and digest output
module she_back import she_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [31:0]  out_word,
   output logic [2:0]   out_index,
   output logic         out_last
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_ADD, ST_EMIT
   } state_type;

   state_type    state_ff;
   logic [31:0]  buf_ff [16];
   logic [31:0]  w_ff [16];
   logic [31:0]  h_ff [8];
   logic [31:0]  v_ff [8];
   logic [63:0]  count_ff;
   logic [63:0]  bits_ff;
   logic [5:0]   pos_ff;
   logic [5:0]   round_ff;
   logic         final_ff;
   logic         pad_ff;
   logic [2:0]   idx_ff;
   logic         out_valid_ff;
   logic [31:0]  out_word_ff;
   logic [2:0]   out_index_ff;
   logic         out_last_ff;

   logic [31:0]  x, s0, s1, ch, mj, t1, t2, a2, a15;
   logic [3:0]   r4;
   logic [31:0]  byte_mask, byte_val;

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;
   assign out_index = out_index_ff;
   assign out_last  = out_last_ff;

   // message schedule and round logic
   always_comb begin
      r4  = round_ff[3:0];
      a2  = w_ff[r4 - 4'd2];
      a15 = w_ff[r4 - 4'd15];
      if (round_ff < 6'd16) begin
         x = buf_ff[r4];
      end else begin
         x = (rotr(a2, 17) ^ rotr(a2, 19) ^ (a2 >> 10)) + w_ff[r4 - 4'd7]
           + (rotr(a15, 7) ^ rotr(a15, 18) ^ (a15 >> 3)) + w_ff[r4];
      end
      s1 = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1 = v_ff[7] + s1 + ch + ROUND_CONST[round_ff] + x;
      s0 = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      mj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2 = s0 + mj;
      byte_mask = 32'hFF << (8 * (3 - pos_ff[1:0]));
      byte_val  = {24'd0, in_item.data_byte} << (8 * (3 - pos_ff[1:0]));
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pos_ff       <= '0;
         final_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < 8; k++) h_ff[k] <= INIT_HASH[k];
      end else begin
         if (out_valid_ff && out_ready && state_ff != ST_EMIT) out_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (in_valid) begin
                  if (!in_item.finish) begin
                     buf_ff[pos_ff[5:2]] <= (buf_ff[pos_ff[5:2]] & ~byte_mask) | byte_val;
                     count_ff <= count_ff + 64'd1;
                     pos_ff   <= pos_ff + 6'd1;
                     if (pos_ff == 6'd63) begin
                        final_ff <= 1'b0;
                        state_ff <= ST_LOAD;
                     end
                  end else begin
                     bits_ff <= {count_ff[60:0], 3'b000};
                     buf_ff[pos_ff[5:2]] <= (buf_ff[pos_ff[5:2]] & ~byte_mask)
                        | ({24'd0, PAD_BYTE} << (8 * (3 - pos_ff[1:0])));
                     pos_ff   <= pos_ff + 6'd1;
                     // pad byte in the last slot fills the block at once
                     if (pos_ff == 6'd63) begin
                        final_ff <= 1'b0;
                        state_ff <= ST_LOAD;
                     end else begin
                        state_ff <= ST_PAD;
                     end
                  end
               end
            end
            ST_PAD: begin
               // zero fill one byte per cycle, length when reaching its slot; a full block is compressed first
               if (pos_ff == LEN_POS) begin
                  buf_ff[14] <= bits_ff[63:32];
                  buf_ff[15] <= bits_ff[31:0];
                  final_ff   <= 1'b1;
                  pos_ff     <= '0;
                  state_ff   <= ST_LOAD;
               end else begin
                  buf_ff[pos_ff[5:2]] <= buf_ff[pos_ff[5:2]] & ~byte_mask;
                  pos_ff <= pos_ff + 6'd1;
                  if (pos_ff == 6'd63) begin
                     final_ff <= 1'b0;
                     state_ff <= ST_LOAD;
                  end
               end
            end
            ST_LOAD: begin
               for (int k = 0; k < 8; k++) v_ff[k] <= h_ff[k];
               round_ff <= '0;
               state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               w_ff[r4] <= x;
               v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               round_ff <= round_ff + 6'd1;
               if (round_ff == 6'd63) state_ff <= ST_ADD;
            end
            ST_ADD: begin
               for (int k = 0; k < 8; k++) h_ff[k] <= h_ff[k] + v_ff[k];
               idx_ff <= '0;
               if (final_ff) state_ff <= ST_EMIT;
               else if (pad_ff) state_ff <= ST_PAD;
               else state_ff <= ST_IDLE;
            end
            ST_EMIT: begin
               if (!out_valid_ff || out_ready) begin
                  out_valid_ff <= 1'b1;
                  out_word_ff  <= h_ff[idx_ff];
                  out_index_ff <= idx_ff;
                  out_last_ff  <= (idx_ff == 3'd7);
                  idx_ff       <= idx_ff + 3'd1;
                  if (idx_ff == 3'd7) begin
                     for (int k = 0; k < 8; k++) h_ff[k] <= INIT_HASH[k];
                     count_ff <= '0;
                     pos_ff   <= '0;
                     final_ff <= 1'b0;
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // padding started by a finish request, held until the digest output state
   always_ff @(posedge clock) begin
      if (reset) pad_ff <= 1'b0;
      else if (state_ff == ST_IDLE && in_valid && in_item.finish) pad_ff <= 1'b1;
      else if (state_ff == ST_EMIT) pad_ff <= 1'b0;
   end

   `SHE_ASSERT_IMPL(a_ready_idle, clock, reset, in_ready, state_ff == ST_IDLE, "ready outside idle")
   `SHE_ASSERT_NEXT(a_round_step, clock, reset, state_ff == ST_ROUND && round_ff != 6'd63,
      state_ff == ST_ROUND, "round loop broke early")
   `SHE_ASSERT_IMPL(a_last_idx, clock, reset, out_valid_ff && out_last_ff, out_index_ff == 3'd7,
      "last flag off word seven")
endmodule

// ===== hw/rtl/sha256_hash_engine_core.sv =====
`timescale 1ns / 1ps
// a byte that fills a block starts a compression (load, rounds, add); finish pads the
// block, runs one or two compressions, then emits 8 digest words
// the single round unit does 1 round per cycle; requests queue up in the front meanwhile
// reset: synchronous, restores initial hash values and a zero byte count
module sha256_hash_engine_core import she_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic        req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // digest_word[31:0]
   output logic [2:0]  rsp_tuser,   // word_index[2:0]
   output logic        rsp_tlast    // last_word
);
   req_item_type in_item, q_item;
   logic         q_valid, q_ready;

   assign in_item.finish    = req_tuser;
   assign in_item.data_byte = req_tdata;

   she_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(in_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item));

   she_back u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_word(rsp_tdata), .out_index(rsp_tuser), .out_last(rsp_tlast));
endmodule

// ===== bench/sha256_hash_engine_core_test.sv =====
`timescale 1ns / 1ps
module sha256_hash_engine_core_test;
   import she_pkg::*;

   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;
   localparam int unsigned IDLE_LIMIT = 20000;

   // expected digest word
   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   // digest predictor and store of expected words
   class digest_scoreboard;
      logic [31:0]     hash_state [8];
      logic [7:0]      block_bytes [64];
      logic [63:0]     byte_total;
      digest_word_type pending_words [$];
      int unsigned     mismatches;

      function new();
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         for (int k = 0; k < 8; k++) hash_state[k] = INIT_HASH[k];
         byte_total = '0;
      endfunction

      function logic [31:0] rot(logic [31:0] v, int n);
         return (v >> n) | (v << (32 - n));
      endfunction

      function void compress();
         logic [31:0] w [64];
         logic [31:0] r [8];
         logic [31:0] t1, t2;
         for (int t = 0; t < 16; t++)
            w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
         for (int t = 16; t < 64; t++)
            w[t] = (rot(w[t-2], 17) ^ rot(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (rot(w[t-15], 7) ^ rot(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
         for (int k = 0; k < 8; k++) r[k] = hash_state[k];
         for (int t = 0; t < 64; t++) begin
            t1 = r[7] + (rot(r[4], 6) ^ rot(r[4], 11) ^ rot(r[4], 25))
               + ((r[4] & r[5]) ^ (~r[4] & r[6])) + ROUND_CONST[t] + w[t];
            t2 = (rot(r[0], 2) ^ rot(r[0], 13) ^ rot(r[0], 22))
               + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
            r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
            r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
         end
         for (int k = 0; k < 8; k++) hash_state[k] += r[k];
      endfunction

      // note one accepted request
      function void note_request(logic op, logic [7:0] data);
         int pos;
         logic [63:0] bits;
         digest_word_type d;
         pos = byte_total[5:0];
         if (op == OP_ABSORB) begin
            block_bytes[pos] = data;
            byte_total++;
            if (byte_total[5:0] == 0) compress();
            return;
         end
         bits = byte_total << 3;
         block_bytes[pos++] = PAD_BYTE;
         if (pos > LEN_POS) begin
            while (pos < 64) block_bytes[pos++] = 8'h00;
            compress();
            pos = 0;
         end
         while (pos < LEN_POS) block_bytes[pos++] = 8'h00;
         for (int k = 0; k < 8; k++) block_bytes[56+k] = bits[63-8*k -: 8];
         compress();
         for (int k = 0; k < 8; k++) begin
            d.word = hash_state[k];
            d.index = 3'(k);
            d.last = (k == 7);
            pending_words.push_back(d);
         end
         restart();
      endfunction

      // compare one accepted digest word
      function void check_word(logic [31:0] word, logic [2:0] index, logic last);
         digest_word_type d;
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected digest word %h", word);
            return;
         end
         d = pending_words.pop_front();
         if (word !== d.word || index !== d.index || last !== d.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                        d.word, d.index, d.last, word, index, last);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = OP_ABSORB;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   digest_scoreboard board = new();
   int unsigned send_idle_pct = 6;
   int unsigned recv_idle_pct = 72;
   int unsigned idle_cycles = 0;

   sha256_hash_engine_core i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // random receiver stalls
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // drive one request, with random sender gaps
   task automatic send_request(logic op, logic [7:0] data);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_message(int len, bit fixed, logic [7:0] value);
      for (int k = 0; k < len; k++)
         send_request(OP_ABSORB, fixed ? value : 8'($urandom));
      send_request(OP_FINISH, 8'($urandom));
   endtask

   task automatic random_phase(int items);
      int sent;
      int len;
      sent = 0;
      while (sent < items) begin
         case ($urandom_range(9))
            0: len = 55 + $urandom_range(10);
            1: len = 110 + $urandom_range(20);
            default: len = $urandom_range(20);
         endcase
         send_message(len, 1'b0, 8'h00);
         sent += len + 1;
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending_words.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // empty message right after reset, then finish after finish
      send_request(OP_FINISH, 8'hFF);
      send_request(OP_FINISH, 8'h00);
      // byte extremes, then short messages of random bytes
      send_message(3, 1'b1, 8'hFF);
      send_message(1, 1'b1, 8'h00);
      send_message(3, 1'b0, 8'h00);
      send_message(9, 1'b0, 8'h00);
      random_phase(50);
      drain();
      send_idle_pct = 72;
      recv_idle_pct = 6;
      send_message(56, 1'b0, 8'h00);
      random_phase(50);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_message(64, 1'b0, 8'h00);
      random_phase(40);
      drain();
      if (board.mismatches == 0 && board.pending_words.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
